// ----- design/tlq_pkg.sv -----
// ----------------------------------------------------------------------------
// tlq_pkg
// shared widths, constants and pipeline item type for the thick line quad block
// ----------------------------------------------------------------------------
package tlq_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int UNIT_FRAC  = 15;
  localparam int WIDTH_BITS = 10;
  localparam int OUT_W      = COORD_BITS + FRAC_BITS + 2;
  localparam int D_W        = COORD_BITS + 1;       // difference
  localparam int SQ_W       = 2 * D_W;              // square of a difference
  localparam int L2_W       = SQ_W + 1;             // squared length
  localparam int Q_W        = UNIT_FRAC + 1;        // unit magnitude 0..2^15
  localparam int NCELLS     = Q_W;
  localparam int IDX_W      = $clog2(NCELLS);
  localparam int WW         = L2_W + 2 * Q_W + 6;   // search accumulators

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [WW-1:0]         acc_t;

  typedef struct packed {
    coord_t            sx;
    coord_t            sy;
    coord_t            ex;
    coord_t            ey;
    logic              degen;
    logic              negx;
    logic              negy;
    logic [L2_W-1:0]   len2;
    logic [SQ_W-1:0]   cx2;
    logic [SQ_W-1:0]   cy2;
    logic [Q_W-1:0]    qx;
    logic [Q_W-1:0]    qy;
    acc_t              sxa;   // k^2 * len2 for x
    acc_t              pxa;   // k * len2 for x
    acc_t              sya;
    acc_t              pya;
  } item_t;

endpackage

// ----- design/thick_line_quad_corners.sv -----
// ----------------------------------------------------------------------------
// thick_line_quad_corners
// turns a line segment into the four corners of its quad at the set width
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  segment  | in_valid_i/in_ready_o  | start_x_i start_y_i end_x_i end_y_i
//  corners  | out_valid_o/out_ready_i| corner_[a-d]_[xy]_o degenerate_o
//  config   | cfg_valid_i/cfg_ready_o| cfg_line_width_i
//
//  one segment per clock while out_ready_i holds; three setup stages (difference,
//  squares, length), one cell per unit vector bit (16), offset and corner stages
//  reset clears every stage valid and sets line width to 1
//  each stage holds while its successor is full, so bubbles close up under stall
// ----------------------------------------------------------------------------
module thick_line_quad_corners (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tlq_pkg::WIDTH_BITS-1:0]    cfg_line_width_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [tlq_pkg::COORD_BITS-1:0] start_x_i,
  input  logic signed [tlq_pkg::COORD_BITS-1:0] start_y_i,
  input  logic signed [tlq_pkg::COORD_BITS-1:0] end_x_i,
  input  logic signed [tlq_pkg::COORD_BITS-1:0] end_y_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [tlq_pkg::OUT_W-1:0]  corner_a_x_o,
  output logic signed [tlq_pkg::OUT_W-1:0]  corner_a_y_o,
  output logic signed [tlq_pkg::OUT_W-1:0]  corner_b_x_o,
  output logic signed [tlq_pkg::OUT_W-1:0]  corner_b_y_o,
  output logic signed [tlq_pkg::OUT_W-1:0]  corner_c_x_o,
  output logic signed [tlq_pkg::OUT_W-1:0]  corner_c_y_o,
  output logic signed [tlq_pkg::OUT_W-1:0]  corner_d_x_o,
  output logic signed [tlq_pkg::OUT_W-1:0]  corner_d_y_o,
  output logic                              degenerate_o
);
  import tlq_pkg::*;

  logic [WIDTH_BITS-1:0] line_width_q;

  logic            v1_q, v2_q, v3_q, r1, r2, r3;
  coord_t          sx1_q, sy1_q, ex1_q, ey1_q, sx2_q, sy2_q, ex2_q, ey2_q;
  logic signed [D_W-1:0] dx1_q, dy1_q;
  logic [D_W-1:0]  adx, ady;
  logic [SQ_W-1:0] cx2_q, cy2_q;
  logic            nx2_q, ny2_q, dg2_q;
  item_t           it3_q;
  logic [L2_W-1:0] len2_d;

  logic  cv [NCELLS+1];
  logic  cr [NCELLS+1];
  item_t cd [NCELLS+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= WIDTH_BITS'(1);
    end else if (cfg_valid_i) begin
      line_width_q <= cfg_line_width_i;
    end
  end

  assign r3         = !v3_q || cr[0];
  assign r2         = !v2_q || r3;
  assign r1         = !v1_q || r2;
  assign in_ready_o = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  assign adx    = dx1_q[D_W-1] ? D_W'(-dx1_q) : D_W'(dx1_q);
  assign ady    = dy1_q[D_W-1] ? D_W'(-dy1_q) : D_W'(dy1_q);
  assign len2_d = {1'b0, cx2_q} + {1'b0, cy2_q};

  always_ff @(posedge clk_i) begin
    if (r1 && in_valid_i) begin
      sx1_q <= start_x_i;
      sy1_q <= start_y_i;
      ex1_q <= end_x_i;
      ey1_q <= end_y_i;
      dx1_q <= D_W'(end_x_i) - D_W'(start_x_i);
      dy1_q <= D_W'(end_y_i) - D_W'(start_y_i);
    end
    if (r2 && v1_q) begin
      sx2_q <= sx1_q;
      sy2_q <= sy1_q;
      ex2_q <= ex1_q;
      ey2_q <= ey1_q;
      cx2_q <= {{D_W{1'b0}}, adx} * {{D_W{1'b0}}, adx};
      cy2_q <= {{D_W{1'b0}}, ady} * {{D_W{1'b0}}, ady};
      nx2_q <= dx1_q[D_W-1];
      ny2_q <= dy1_q[D_W-1];
      dg2_q <= (dx1_q == '0) && (dy1_q == '0);
    end
    if (r3 && v2_q) begin
      it3_q.sx    <= sx2_q;
      it3_q.sy    <= sy2_q;
      it3_q.ex    <= ex2_q;
      it3_q.ey    <= ey2_q;
      it3_q.degen <= dg2_q;
      it3_q.negx  <= nx2_q;
      it3_q.negy  <= ny2_q;
      it3_q.len2  <= len2_d;
      it3_q.cx2   <= cx2_q;
      it3_q.cy2   <= cy2_q;
      it3_q.qx    <= '0;
      it3_q.qy    <= '0;
      // q = 0 means k = -1
      it3_q.sxa   <= $signed({{(WW-L2_W){1'b0}}, len2_d});
      it3_q.pxa   <= -$signed({{(WW-L2_W){1'b0}}, len2_d});
      it3_q.sya   <= $signed({{(WW-L2_W){1'b0}}, len2_d});
      it3_q.pya   <= -$signed({{(WW-L2_W){1'b0}}, len2_d});
    end
  end

  assign cv[0] = v3_q;
  assign cd[0] = it3_q;

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    tlq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .bit_idx_i   (IDX_W'(NCELLS - 1 - i)),
      .in_valid_i  (cv[i]),
      .in_ready_o  (cr[i]),
      .in_data_i   (cd[i]),
      .out_valid_o (cv[i+1]),
      .out_ready_i (cr[i+1]),
      .out_data_o  (cd[i+1])
    );
  end

  tlq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .line_width_i (line_width_q),
    .in_valid_i   (cv[NCELLS]),
    .in_ready_o   (cr[NCELLS]),
    .in_data_i    (cd[NCELLS]),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .corner_a_x_o (corner_a_x_o),
    .corner_a_y_o (corner_a_y_o),
    .corner_b_x_o (corner_b_x_o),
    .corner_b_y_o (corner_b_y_o),
    .corner_c_x_o (corner_c_x_o),
    .corner_c_y_o (corner_c_y_o),
    .corner_d_x_o (corner_d_x_o),
    .corner_d_y_o (corner_d_y_o),
    .degenerate_o (degenerate_o)
  );

  // a zero-length segment collapses all corners onto the start point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      corner_a_x_o == corner_c_x_o && corner_a_y_o == corner_c_y_o &&
      corner_b_x_o == corner_d_x_o && corner_b_y_o == corner_d_y_o)
    else $error("degenerate segment with spread corners");

  // zero width puts both start corners on the start point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_width_q == '0 |->
      corner_a_x_o == corner_b_x_o && corner_a_y_o == corner_b_y_o)
    else $error("zero width gives non-zero offset");

  // the first stage only moves when it has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !r2 |=> v1_q && $stable(dx1_q))
    else $error("setup stage lost an item under stall");

endmodule

// ----- design/tlq_cell.sv -----
// ----------------------------------------------------------------------------
// tlq_cell
// one bit of the rounded unit vector search for both components
// ----------------------------------------------------------------------------
module tlq_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [tlq_pkg::IDX_W-1:0] bit_idx_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  tlq_pkg::item_t           in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output tlq_pkg::item_t           out_data_o
);
  import tlq_pkg::*;

  logic  valid_q;
  item_t data_q, data_d;
  acc_t  len_w, sxn, pxn, syn, pyn, limx, limy;

  assign in_ready_o = !valid_q || out_ready_i;

  // trial bit raises k = 2q-1 by 2^(j+1): k^2 grows by 2^(j+2)k + 2^(2j+2)
  always_comb begin
    len_w  = $signed({{(WW-L2_W){1'b0}}, in_data_i.len2});
    limx   = $signed({{(WW-SQ_W){1'b0}}, in_data_i.cx2}) <<< 32;
    limy   = $signed({{(WW-SQ_W){1'b0}}, in_data_i.cy2}) <<< 32;
    sxn    = in_data_i.sxa + (in_data_i.pxa <<< (bit_idx_i + 2))
             + (len_w <<< (2 * bit_idx_i + 2));
    pxn    = in_data_i.pxa + (len_w <<< (bit_idx_i + 1));
    syn    = in_data_i.sya + (in_data_i.pya <<< (bit_idx_i + 2))
             + (len_w <<< (2 * bit_idx_i + 2));
    pyn    = in_data_i.pya + (len_w <<< (bit_idx_i + 1));
    data_d = in_data_i;
    if (sxn <= limx) begin
      data_d.qx[bit_idx_i] = 1'b1;
      data_d.sxa = sxn;
      data_d.pxa = pxn;
    end
    if (syn <= limy) begin
      data_d.qy[bit_idx_i] = 1'b1;
      data_d.sya = syn;
      data_d.pya = pyn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- design/tlq_back.sv -----
// ----------------------------------------------------------------------------
// tlq_back
// half width offsets and corner sums, with the output register
// ----------------------------------------------------------------------------
module tlq_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [tlq_pkg::WIDTH_BITS-1:0]  line_width_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  tlq_pkg::item_t                  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [tlq_pkg::OUT_W-1:0] corner_a_x_o,
  output logic signed [tlq_pkg::OUT_W-1:0] corner_a_y_o,
  output logic signed [tlq_pkg::OUT_W-1:0] corner_b_x_o,
  output logic signed [tlq_pkg::OUT_W-1:0] corner_b_y_o,
  output logic signed [tlq_pkg::OUT_W-1:0] corner_c_x_o,
  output logic signed [tlq_pkg::OUT_W-1:0] corner_c_y_o,
  output logic signed [tlq_pkg::OUT_W-1:0] corner_d_x_o,
  output logic signed [tlq_pkg::OUT_W-1:0] corner_d_y_o,
  output logic                            degenerate_o
);
  import tlq_pkg::*;

  localparam int PW = WIDTH_BITS + Q_W + FRAC_BITS + 1;

  typedef logic signed [OUT_W-1:0] out_t;

  logic            a_valid_q, b_valid_q, a_ready, b_ready;
  out_t            sx_q, sy_q, ex_q, ey_q, offx_q, offy_q;
  logic            degen_a_q;
  logic [PW-1:0]   px, py, rx, ry;
  out_t            offx_d, offy_d;
  out_t            a_x_q, a_y_q, b_x_q, b_y_q, c_x_q, c_y_q, d_x_q, d_y_q;
  logic            degen_b_q;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_comb begin
    px = ({{(PW-WIDTH_BITS){1'b0}}, line_width_i} * {{(PW-Q_W){1'b0}}, in_data_i.qx})
         << FRAC_BITS;
    py = ({{(PW-WIDTH_BITS){1'b0}}, line_width_i} * {{(PW-Q_W){1'b0}}, in_data_i.qy})
         << FRAC_BITS;
    rx = (px + (PW'(1) << UNIT_FRAC)) >> (UNIT_FRAC + 1);
    ry = (py + (PW'(1) << UNIT_FRAC)) >> (UNIT_FRAC + 1);
    offx_d = in_data_i.negx ? -$signed(OUT_W'(rx)) : $signed(OUT_W'(rx));
    offy_d = in_data_i.negy ? -$signed(OUT_W'(ry)) : $signed(OUT_W'(ry));
    if (in_data_i.degen) begin
      offx_d = '0;
      offy_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      sx_q      <= OUT_W'(in_data_i.sx) <<< FRAC_BITS;
      sy_q      <= OUT_W'(in_data_i.sy) <<< FRAC_BITS;
      ex_q      <= OUT_W'(in_data_i.degen ? in_data_i.sx : in_data_i.ex) <<< FRAC_BITS;
      ey_q      <= OUT_W'(in_data_i.degen ? in_data_i.sy : in_data_i.ey) <<< FRAC_BITS;
      offx_q    <= offx_d;
      offy_q    <= offy_d;
      degen_a_q <= in_data_i.degen;
    end
    if (b_ready && a_valid_q) begin
      a_x_q     <= sx_q - offy_q;
      a_y_q     <= sy_q + offx_q;
      b_x_q     <= sx_q + offy_q;
      b_y_q     <= sy_q - offx_q;
      c_x_q     <= ex_q + offy_q;
      c_y_q     <= ey_q - offx_q;
      d_x_q     <= ex_q - offy_q;
      d_y_q     <= ey_q + offx_q;
      degen_b_q <= degen_a_q;
    end
  end

  assign out_valid_o  = b_valid_q;
  assign corner_a_x_o = a_x_q;
  assign corner_a_y_o = a_y_q;
  assign corner_b_x_o = b_x_q;
  assign corner_b_y_o = b_y_q;
  assign corner_c_x_o = c_x_q;
  assign corner_c_y_o = c_y_q;
  assign corner_d_x_o = d_x_q;
  assign corner_d_y_o = d_y_q;
  assign degenerate_o = degen_b_q;

endmodule

// ----- verif/tlq_corner_checker.sv -----
// ----------------------------------------------------------------------------
// tlq_corner_checker
// Watches the segment, corner and config channels of thick_line_quad_corners.
// Each accepted segment is turned into its expected quad corners at the
// current line width. Each accepted corner set is compared field by field.
// ----------------------------------------------------------------------------
module tlq_corner_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic                                  cfg_ready_i,
  input  logic [tlq_pkg::WIDTH_BITS-1:0]        cfg_line_width_i,
  input  logic                                  in_valid_i,
  input  logic                                  in_ready_i,
  input  logic signed [tlq_pkg::COORD_BITS-1:0] start_x_i,
  input  logic signed [tlq_pkg::COORD_BITS-1:0] start_y_i,
  input  logic signed [tlq_pkg::COORD_BITS-1:0] end_x_i,
  input  logic signed [tlq_pkg::COORD_BITS-1:0] end_y_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_ready_i,
  input  logic signed [tlq_pkg::OUT_W-1:0]      corner_a_x_i,
  input  logic signed [tlq_pkg::OUT_W-1:0]      corner_a_y_i,
  input  logic signed [tlq_pkg::OUT_W-1:0]      corner_b_x_i,
  input  logic signed [tlq_pkg::OUT_W-1:0]      corner_b_y_i,
  input  logic signed [tlq_pkg::OUT_W-1:0]      corner_c_x_i,
  input  logic signed [tlq_pkg::OUT_W-1:0]      corner_c_y_i,
  input  logic signed [tlq_pkg::OUT_W-1:0]      corner_d_x_i,
  input  logic signed [tlq_pkg::OUT_W-1:0]      corner_d_y_i,
  input  logic                                  degenerate_i,
  output int                                    pending_o,
  output int                                    err_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import tlq_pkg::*;

  typedef struct packed {
    logic [7:0][OUT_W-1:0] corner;   // ax ay bx by cx cy dx dy
    logic                  degen;
  } quad_t;

  quad_t                 quads_due[$];
  logic [WIDTH_BITS-1:0] width_q;

  // largest q with (2q-1)^2 * len2 <= comp^2 * 2^32, i.e. rounded |comp|/len in Q1.15
  function automatic longint unit_mag(longint comp, longint len2);
    logic [127:0] lhs, rhs, k;
    longint lo, hi, mid, mag;
    mag = comp < 0 ? -comp : comp;
    rhs = (128'(mag) * 128'(mag)) << 32;
    lo = 0;
    hi = 64'd1 << UNIT_FRAC;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      k = 128'(2 * mid - 1);
      lhs = k * k * 128'(len2);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return comp < 0 ? -lo : lo;
  endfunction

  function automatic longint half_offset(longint u, longint w);
    longint mag, r;
    mag = u < 0 ? -u : u;
    r = (((w * mag) << FRAC_BITS) + (64'd1 << UNIT_FRAC)) >> (UNIT_FRAC + 1);
    return u < 0 ? -r : r;
  endfunction

  function automatic quad_t quad_of(longint sx, longint sy, longint ex, longint ey,
                                    longint w);
    quad_t  q;
    longint dx, dy, offx, offy, len2;
    dx = ex - sx;
    dy = ey - sy;
    offx = 0;
    offy = 0;
    q.degen = (dx == 0 && dy == 0);
    if (q.degen) begin
      ex = sx;
      ey = sy;
    end else begin
      len2 = dx * dx + dy * dy;
      offx = half_offset(unit_mag(dx, len2), w);
      offy = half_offset(unit_mag(dy, len2), w);
    end
    sx = sx <<< FRAC_BITS;
    sy = sy <<< FRAC_BITS;
    ex = ex <<< FRAC_BITS;
    ey = ey <<< FRAC_BITS;
    q.corner[0] = OUT_W'(sx - offy);
    q.corner[1] = OUT_W'(sy + offx);
    q.corner[2] = OUT_W'(sx + offy);
    q.corner[3] = OUT_W'(sy - offx);
    q.corner[4] = OUT_W'(ex + offy);
    q.corner[5] = OUT_W'(ey - offx);
    q.corner[6] = OUT_W'(ex - offy);
    q.corner[7] = OUT_W'(ey + offx);
    return q;
  endfunction

  assign pending_o = quads_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    quad_t got, want;
    if (!rst_ni) begin
      width_q     <= WIDTH_BITS'(1);
      err_count_o <= 0;
      quads_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) width_q <= cfg_line_width_i;
      if (in_valid_i && in_ready_i)
        quads_due.push_back(quad_of(start_x_i, start_y_i, end_x_i, end_y_i, width_q));
      if (out_valid_i && out_ready_i) begin
        got.corner = {corner_d_y_i, corner_d_x_i, corner_c_y_i, corner_c_x_i,
                      corner_b_y_i, corner_b_x_i, corner_a_y_i, corner_a_x_i};
        got.degen  = degenerate_i;
        if (quads_due.size() == 0) begin
          if (err_count_o < 10) $display("corner transfer with nothing outstanding");
          err_count_o <= err_count_o + 1;
        end else begin
          want = quads_due.pop_front();
          if (got != want) begin
            if (err_count_o < 10)
              $display("corner mismatch: expected %h degen %b, got %h degen %b",
                       want.corner, want.degen, got.corner, got.degen);
            err_count_o <= err_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ----- verif/thick_line_quad_corners_tb.sv -----
// ----------------------------------------------------------------------------
// thick_line_quad_corners_tb
// Drives segments through thick_line_quad_corners at several line widths,
// directed extremes first, then bursty random traffic under random back
// pressure; the checker beside the block predicts and compares every quad.
// ----------------------------------------------------------------------------
module thick_line_quad_corners_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlq_pkg::*;

  localparam int RAND_SEGS = 1500;
  localparam int CYCLE_CAP = 300000;
  localparam int DRAIN_GAP = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0, cfg_ready_o;
  logic [WIDTH_BITS-1:0] cfg_line_width_i = '0;
  logic in_valid_i = 1'b0, in_ready_o;
  logic signed [COORD_BITS-1:0] start_x_i = '0, start_y_i = '0, end_x_i = '0, end_y_i = '0;
  logic out_valid_o, out_ready_i = 1'b0;
  logic signed [OUT_W-1:0] corner_a_x_o, corner_a_y_o, corner_b_x_o, corner_b_y_o;
  logic signed [OUT_W-1:0] corner_c_x_o, corner_c_y_o, corner_d_x_o, corner_d_y_o;
  logic degenerate_o;
  int   pending, err_count, cycles = 0;
  logic hold_req = 1'b0;

  thick_line_quad_corners dut (.*);

  tlq_corner_checker checker_i (
    .cfg_ready_i(cfg_ready_o), .in_ready_i(in_ready_o), .out_valid_i(out_valid_o),
    .corner_a_x_i(corner_a_x_o), .corner_a_y_i(corner_a_y_o),
    .corner_b_x_i(corner_b_x_o), .corner_b_y_i(corner_b_y_o),
    .corner_c_x_i(corner_c_x_o), .corner_c_y_i(corner_c_y_o),
    .corner_d_x_i(corner_d_x_o), .corner_d_y_i(corner_d_y_o),
    .degenerate_i(degenerate_o), .pending_o(pending), .err_count_o(err_count), .*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stall mode, redrawn periodically, long hold-off on request
  initial begin
    int mode, hold_left;
    mode = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (cycles % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_req && hold_left == 0) hold_left = 300;
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
        if (hold_left == 0) hold_req = 1'b0;
      end else begin
        case (mode)
          0:       out_ready_i = 1'b1;
          1:       out_ready_i = ($urandom_range(0, 1) == 1);
          2:       out_ready_i = ($urandom_range(0, 7) != 0);
          default: out_ready_i = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  int burst_left = 0;

  task automatic send_seg(int sx, int sy, int ex, int ey);
    if (burst_left == 0) begin
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    start_x_i  = COORD_BITS'(sx);
    start_y_i  = COORD_BITS'(sy);
    end_x_i    = COORD_BITS'(ex);
    end_y_i    = COORD_BITS'(ey);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  task automatic set_width(int w);
    @(negedge clk_i);
    cfg_valid_i      = 1'b1;
    cfg_line_width_i = WIDTH_BITS'(w);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic rand_segs(int n);
    int sx, sy;
    repeat (n) begin
      sx = $signed(16'($urandom));
      sy = $signed(16'($urandom));
      case ($urandom_range(0, 9))
        0:       send_seg(sx, sy, sx, sy);                      // zero length
        1, 2, 3: send_seg(sx, sy, $signed(16'(sx + $urandom_range(0, 8) - 4)),
                          $signed(16'(sy + $urandom_range(0, 8) - 4)));
        4:       send_seg(sx, sy, sx, $signed(16'($urandom)));  // vertical
        5:       send_seg(sx, sy, $signed(16'($urandom)), sy);  // horizontal
        default: send_seg(sx, sy, $signed(16'($urandom)), $signed(16'($urandom)));
      endcase
    end
  endtask

  initial begin
    int widths[6];
    widths = '{0, 1023, 7, 1023, 2, 1};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed segments at reset width
    send_seg(-32768, -32768, 32767, 32767);
    send_seg(32767, -32768, -32768, 32767);
    send_seg(32767, 32767, -32768, -32768);
    send_seg(-32768, 0, 32767, 0);
    send_seg(0, 32767, 0, -32768);
    send_seg(-32768, -32768, -32768, -32768);
    send_seg(32767, 32767, 32767, 32767);
    send_seg(0, 0, 0, 0);
    send_seg(0, 0, 1, 0);
    send_seg(0, 0, 0, -1);
    send_seg(0, 0, 1, 1);
    send_seg(0, 0, -1, 2);
    send_seg(5, 5, 8, 9);
    send_seg(-1, -1, -4, -5);
    send_seg(100, -200, 100, -200);
    drain();
    set_width(1023);
    send_seg(-32768, -32768, 32767, 32767);
    send_seg(32767, -32768, -32768, 32767);
    send_seg(0, 0, 1, 2);
    send_seg(-32768, 32767, -32768, -32768);
    send_seg(0, 0, -3, 4);
    drain();

    foreach (widths[i]) begin
      set_width(i == 2 ? $urandom_range(2, 1022) : widths[i]);
      if (i == 1) hold_req = 1'b1;     // block fills and stalls its input
      rand_segs(RAND_SEGS / 6);
      drain();
    end

    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
